// ===== rtl/lcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcmc_pkg: shared constants
// Defaults and field widths for the LRU cache miss counter.
// ----------------------------------------------------------------------------
`default_nettype none
package lcmc_pkg;
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned MATRIX_DIM_DEF = 64;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned COUNT_W  = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
endpackage
`default_nettype wire

// ===== rtl/lcmc_if.sv =====
// ----------------------------------------------------------------------------
// lcmc_if: handshake channels
// Valid/ready channels for references, results and the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none
interface lcmc_in_if;
  logic       valid;
  logic       ready;
  logic       matrix_sel;
  logic [5:0] row;
  logic [5:0] col;
  modport source (output valid, matrix_sel, row, col, input ready);
  modport sink   (input valid, matrix_sel, row, col, output ready);
endinterface

interface lcmc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted;
  logic [31:0] miss_count;
  modport source (output valid, hit, evicted, miss_count, input ready);
  modport sink   (input valid, hit, evicted, miss_count, output ready);
endinterface

interface lcmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcmc_ram.sv =====
// ----------------------------------------------------------------------------
// lcmc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lcmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                          wdata,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // A read at a written address returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/lru_cache_miss_counter_top.sv =====
// ----------------------------------------------------------------------------
// lru_cache_miss_counter_top: fully associative LRU cache miss counter
// Presence table and linked recency list held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Result path: a hit on the newest entry, or a miss on an empty zero-capacity
// cache, goes S_LOOK then S_OUT; a miss into a free slot goes S_LOOK, S_INSERT,
// S_OUT; a hit that moves an entry goes S_LOOK, S_UNLINK, S_LINK, S_OUT, and a
// miss that evicts goes S_LOOK, S_EVICT, S_PSET, S_OUT.
// A new reference is taken only in S_IDLE, after the last result beat is taken.
// Reset: rst clears the registers, then the presence RAM is swept clean, one entry a
// cycle, all 2*MATRIX_DIM*MATRIX_DIM entries (8192 by default), before the first beat.
`default_nettype none
module lru_cache_miss_counter_top
  import lcmc_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned MATRIX_DIM = MATRIX_DIM_DEF
) (
  input wire logic clk,
  input wire logic rst,
  lcmc_in_if.sink    in_ch,
  lcmc_out_if.source out_ch,
  lcmc_cfg_if.sink   cfg
);
  localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned DIM_W  = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
  localparam int unsigned KEYS   = 2 * MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned KEY_W  = $clog2(KEYS);
  localparam int unsigned OCC_W  = $clog2(CAPACITY + 1);
  localparam int unsigned PT_W   = 1 + SLOT_W;
  localparam int unsigned IDX_N  = 1 << IDX_W;

  // State codes.
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOOK   = 4'd2;  // presence read returns
  localparam logic [3:0] S_UNLINK = 4'd3;  // hit: take the entry out of the list
  localparam logic [3:0] S_LINK   = 4'd4;  // hit: append the entry as newest
  localparam logic [3:0] S_EVICT  = 4'd5;  // miss: reuse the oldest slot
  localparam logic [3:0] S_PSET   = 4'd6;  // miss: mark the new key present
  localparam logic [3:0] S_INSERT = 4'd7;  // miss: fill a free slot
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]         state;
  logic [KEY_W-1:0]   clr_cnt;
  logic [CAP_W-1:0]   capacity;
  logic [SLOT_W-1:0]  oldest_slot, newest_slot;
  logic [OCC_W-1:0]   occupancy;
  logic [COUNT_W-1:0] miss_total;
  logic [KEY_W-1:0]   key;
  logic               hit, evicted;
  logic [SLOT_W-1:0]  cur;       // slot being moved or filled
  logic               was_oldest;

  // RAM ports. The node store is kept as three column RAMs, each with its own slot address.
  logic              pt_we;  logic [KEY_W-1:0]  pt_addr;
  logic [PT_W-1:0]   pt_wdata, pt_rdata;
  logic              ky_we;  logic [SLOT_W-1:0] ky_addr;
  logic [KEY_W-1:0]  ky_wdata, ky_rdata;
  logic              pr_we;  logic [SLOT_W-1:0] pr_addr;
  logic [SLOT_W-1:0] pr_wdata, pr_rdata;
  logic              nt_we;  logic [SLOT_W-1:0] nt_addr;
  logic [SLOT_W-1:0] nt_wdata, nt_rdata;

  lcmc_ram #(.WIDTH(PT_W), .DEPTH(KEYS)) u_pt (
    .clk, .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rdata));
  lcmc_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ky (
    .clk, .we(ky_we), .addr(ky_addr), .wdata(ky_wdata), .rdata(ky_rdata));
  lcmc_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_pr (
    .clk, .we(pr_we), .addr(pr_addr), .wdata(pr_wdata), .rdata(pr_rdata));
  lcmc_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_nt (
    .clk, .we(nt_we), .addr(nt_addr), .wdata(nt_wdata), .rdata(nt_rdata));

  // Constant table that wraps an index to the matrix size.
  logic [DIM_W-1:0] wrap_tab [IDX_N];
  for (genvar g = 0; g < IDX_N; g++) begin : g_wrap
    assign wrap_tab[g] = DIM_W'(g % MATRIX_DIM);
  end

  // Key from the input beat, indices wrapped to the matrix size.
  logic [DIM_W-1:0] row_w, col_w;
  logic [KEY_W-1:0] in_key;
  assign row_w  = wrap_tab[in_ch.row];
  assign col_w  = wrap_tab[in_ch.col];
  assign in_key = KEY_W'(((32'(in_ch.matrix_sel) * MATRIX_DIM + 32'(row_w))
                  * MATRIX_DIM) + 32'(col_w));

  // Effective capacity and the full test.
  logic [OCC_W-1:0] cap_eff;
  logic             full;
  assign cap_eff = (32'(capacity) > CAPACITY) ? OCC_W'(CAPACITY) : OCC_W'(capacity);
  assign full = ({1'b0, occupancy} + (OCC_W+1)'(1)) > {1'b0, cap_eff};

  // Presence lookup fields and the slot whose node is read next.
  logic              pt_hit;
  logic [SLOT_W-1:0] pt_slot, lk_slot;
  assign pt_hit  = pt_rdata[PT_W-1];
  assign pt_slot = pt_rdata[SLOT_W-1:0];
  assign lk_slot = pt_hit ? pt_slot : oldest_slot;

  assign in_ch.ready    = (state == S_IDLE);
  assign cfg.ready      = (state == S_IDLE);
  assign out_ch.valid   = (state == S_OUT);
  assign out_ch.hit     = hit;
  assign out_ch.evicted = evicted;
  assign out_ch.miss_count = miss_total;

  // RAM port control per state.
  always_comb begin
    pt_we = 1'b0; pt_addr = key; pt_wdata = '0;
    ky_we = 1'b0; ky_addr = cur; ky_wdata = key;
    pr_we = 1'b0; pr_addr = cur; pr_wdata = newest_slot;
    nt_we = 1'b0; nt_addr = cur; nt_wdata = cur;
    case (state)
      S_CLR: begin
        pt_we = 1'b1; pt_addr = clr_cnt;
      end
      S_IDLE: begin
        pt_addr = in_key;
      end
      S_LOOK: begin
        ky_addr = lk_slot; pr_addr = lk_slot; nt_addr = lk_slot;
      end
      S_UNLINK: begin
        // Join the neighbors of an entry in the middle of the list.
        if (!was_oldest) begin
          nt_we = 1'b1; nt_addr = pr_rdata; nt_wdata = nt_rdata;
          pr_we = 1'b1; pr_addr = nt_rdata; pr_wdata = pr_rdata;
        end
      end
      S_LINK: begin
        pr_we = 1'b1; nt_we = 1'b1; nt_addr = newest_slot;
      end
      S_EVICT: begin
        // Drop the victim's key and take over its slot.
        pt_we = 1'b1; pt_addr = ky_rdata;
        ky_we = 1'b1;
        if (occupancy != OCC_W'(1)) begin
          pr_we = 1'b1; nt_we = 1'b1; nt_addr = newest_slot;
        end
      end
      S_PSET: begin
        pt_we = 1'b1; pt_wdata = {1'b1, cur};
      end
      S_INSERT: begin
        pt_we = 1'b1; pt_wdata = {1'b1, cur};
        ky_we = 1'b1;
        if (occupancy != '0) begin
          pr_we = 1'b1; nt_we = 1'b1; nt_addr = newest_slot;
        end
      end
      default: ;
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_cnt <= '0; capacity <= CAP_RESET;
      oldest_slot <= '0; newest_slot <= '0; occupancy <= '0; miss_total <= '0;
      key <= '0; hit <= 1'b0; evicted <= 1'b0; cur <= '0; was_oldest <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.data;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + KEY_W'(1);
          if (clr_cnt == KEY_W'(KEYS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            key <= in_key; state <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit        <= pt_hit;
          was_oldest <= (pt_slot == oldest_slot);
          if (pt_hit) begin
            evicted <= 1'b0;
            cur     <= pt_slot;
            state   <= (pt_slot == newest_slot) ? S_OUT : S_UNLINK;
          end else begin
            if (miss_total != '1) begin
              miss_total <= miss_total + COUNT_W'(1);
            end
            if (full) begin
              evicted <= 1'b1;
              cur     <= oldest_slot;
              state   <= (occupancy == '0) ? S_OUT : S_EVICT;
            end else begin
              evicted <= 1'b0;
              cur     <= SLOT_W'(occupancy);
              state   <= S_INSERT;
            end
          end
        end
        S_UNLINK: begin
          if (was_oldest) begin
            oldest_slot <= nt_rdata;
          end
          state <= S_LINK;
        end
        S_LINK: begin
          newest_slot <= cur;
          state <= S_OUT;
        end
        S_EVICT: begin
          // With one entry left the victim slot stays the oldest.
          if (occupancy != OCC_W'(1)) begin
            oldest_slot <= nt_rdata;
          end
          newest_slot <= cur;
          state <= S_PSET;
        end
        S_PSET: begin
          state <= S_OUT;
        end
        S_INSERT: begin
          if (occupancy == '0) begin
            oldest_slot <= cur;
          end
          newest_slot <= cur;
          occupancy <= occupancy + OCC_W'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  // Assertions.
  a_occ: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= CAPACITY) else $error("occupancy above storage");
  a_hit_noevict: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.hit |-> !out_ch.evicted) else $error("evict on hit");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input open while result waits");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid &&
    $stable({out_ch.hit, out_ch.evicted, out_ch.miss_count}))
    else $error("result changed while waiting");
endmodule
`default_nettype wire
